// File: design/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // Default width of the decoded body byte counter.
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Fixed widths of the beat fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned TOTAL_W = 32;

  // Line delimiter characters.
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // Parser phase. The unused code acts as halted.
  typedef enum logic [2:0] {
    PH_DIGITS  = 3'd0,
    PH_EXT     = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_TRAILER = 3'd5,
    PH_HALT    = 3'd6
  } phase_e;

  // Kind of an output beat.
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_FRAMING   = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_e;

  // One output beat.
  typedef struct packed {
    kind_e               kind;
    logic [BYTE_W-1:0]   body_byte;
    logic [TOTAL_W-1:0]  total_length;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/hcbd_parser.sv
`default_nettype none

module hcbd_parser #(
  parameter int unsigned COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [hcbd_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  wire                            accept_i,
  input  wire  [hcbd_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire                            start_req_i,
  output logic                           res_valid_o,
  output hcbd_pkg::result_t              res_o
);
  import hcbd_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned TW = (CW > TOTAL_W) ? CW : TOTAL_W;

  phase_e             phase_q, phase_d;
  logic               cr_q, cr_d;
  logic [SIZE_W-1:0]  rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               last_q, last_d;
  logic [SIZE_W-1:0]  max_body_q;

  // State as seen by this beat, after an optional start clear.
  phase_e             ph;
  logic               cr;
  logic [SIZE_W-1:0]  rem;
  logic [CW-1:0]      cnt;
  logic               last;
  logic [4:0]         hex;
  logic [TW-1:0]      cnt_ext;
  logic [TW-1:0]      max_ext;
  logic [TW-1:0]      total_ext;

  // Limit register. The user must write it only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= '0;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DIGITS;
      cr_q    <= 1'b0;
      rem_q   <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cr_q    <= cr_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  // One beat of the chunk framing, decided in a single pass.
  always_comb begin
    ph   = phase_q;
    cr   = cr_q;
    rem  = rem_q;
    cnt  = cnt_q;
    last = last_q;
    if (start_req_i) begin
      ph   = PH_DIGITS;
      cr   = 1'b0;
      rem  = '0;
      cnt  = '0;
      last = 1'b0;
    end

    hex     = hex_decode(data_byte_i);
    cnt_ext = TW'(cnt);
    max_ext = TW'(max_body_q);

    phase_d          = phase_q;
    cr_d             = cr_q;
    rem_d            = rem_q;
    cnt_d            = cnt_q;
    last_d           = last_q;
    res_valid_o      = 1'b0;
    res_o.kind       = KIND_BYTE;
    res_o.body_byte  = '0;

    if (accept_i) begin
      phase_d = ph;
      cr_d    = cr;
      rem_d   = rem;
      cnt_d   = cnt;
      last_d  = last;
      unique case (ph)
        PH_DIGITS: begin
          if (hex[4]) begin
            // A digit that would shift a nonzero nibble out of the 32 bits is a framing error.
            if (rem[SIZE_W-1:SIZE_W-4] != 4'd0) begin
              phase_d     = PH_HALT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_FRAMING;
            end else begin
              rem_d = {rem[SIZE_W-5:0], hex[3:0]};
            end
          end else begin
            phase_d = PH_EXT;
            cr_d    = (data_byte_i == CH_CR);
          end
        end
        PH_EXT: begin
          if (cr && data_byte_i == CH_LF) begin
            cr_d = 1'b0;
            if (rem == '0) begin
              last_d  = 1'b1;
              phase_d = PH_TRAILER;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            cr_d = (data_byte_i == CH_CR);
          end
        end
        PH_DATA: begin
          // Saturating byte count; the chunk length is never zero here.
          cnt_d           = cnt + {{(CW-1){1'b0}}, ~&cnt};
          rem_d           = rem - SIZE_W'(1);
          if (rem == SIZE_W'(1)) begin
            phase_d = PH_DATA_CR;
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_BYTE;
          res_o.body_byte = data_byte_i;
        end
        PH_DATA_CR: begin
          if (data_byte_i != CH_CR) begin
            phase_d     = PH_HALT;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_FRAMING;
          end else begin
            phase_d = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (data_byte_i != CH_LF) begin
            phase_d     = PH_HALT;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_FRAMING;
          end else begin
            phase_d = PH_DIGITS;
            rem_d   = '0;
            cr_d    = 1'b0;
          end
        end
        PH_TRAILER: begin
          if (cr && data_byte_i == CH_LF) begin
            cr_d        = 1'b0;
            phase_d     = PH_HALT;
            res_valid_o = 1'b1;
            if (max_body_q != '0 && cnt_ext > max_ext) begin
              res_o.kind = KIND_TOO_LARGE;
            end else begin
              res_o.kind = KIND_DONE;
            end
          end else begin
            cr_d = (data_byte_i == CH_CR);
          end
        end
        default: begin
          // Halted: nothing until a start beat.
        end
      endcase
    end

    // Reported length counts this beat and saturates at the field width.
    total_ext          = TW'(cnt_d);
    res_o.total_length = (total_ext > TW'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                            : total_ext[TOTAL_W-1:0];
  end

  // A terminal result always leaves the parser halted.
  a_terminal_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KIND_BYTE |=> phase_q == PH_HALT)
    else $error("terminal result did not halt the parser");

  // Data phase always has bytes left in the chunk.
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("data phase with empty chunk");

  // The trailer is reached only through the last chunk.
  a_trailer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TRAILER |-> last_q)
    else $error("trailer without last chunk");

endmodule

`default_nettype wire

// File: design/hcbd_out_buf.sv
`default_nettype none

module hcbd_out_buf (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  hcbd_pkg::result_t     push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  output hcbd_pkg::result_t     out_data_o,
  input  wire                   out_stall_i
);
  import hcbd_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid flags of the output register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload of the output register and the skid stage.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (!out_valid_q) begin
      out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  // The skid stage holds a beat only behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat without output beat");

  // The skid stage fills only while the output is stalled.
  a_skid_fill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid filled without a stall");

  // No beat is pushed while the skid stage is occupied.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed into a full buffer");

endmodule

`default_nettype wire

// File: design/http_chunked_body_decoder_top.sv
// Output: each result beat is registered in the output buffer before it leaves the block.
// Throughput: one input beat per cycle while in_stall_o is low, set by the combinational
// parser step; a two-entry output buffer absorbs one beat while the output stalls.
// Reset: rst_ni clears the parser to the size-line state with zero counts
// and sets the size limit register to zero; output beats are dropped.
`default_nettype none

module http_chunked_body_decoder_top #(
  parameter int unsigned COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [hcbd_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [hcbd_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire                            start_req_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [1:0]                     result_kind_o,
  output logic [hcbd_pkg::BYTE_W-1:0]    body_byte_o,
  output logic [hcbd_pkg::TOTAL_W-1:0]   total_length_o
);
  import hcbd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // Chunk framing parser.
  hcbd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register with skid stage.
  hcbd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_stall_i (out_stall_i)
  );

  assign result_kind_o  = out_data.kind;
  assign body_byte_o    = out_data.body_byte;
  assign total_length_o = out_data.total_length;

endmodule

`default_nettype wire

// File: tb/hcbd_body_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the chunked body decoder, predicts every output
// beat from the accepted input beats and compares them in order.
module hcbd_body_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [31:0]  cfg_wdata_i,
  input  wire          in_valid_i,
  input  wire          in_stall_i,
  input  wire  [7:0]   data_byte_i,
  input  wire          start_req_i,
  input  wire          out_valid_i,
  input  wire          out_stall_i,
  input  wire  [1:0]   result_kind_i,
  input  wire  [7:0]   body_byte_i,
  input  wire  [31:0]  total_length_i,
  output int unsigned  mismatch_count_o,
  output int unsigned  pending_beats_o
);

  import hcbd_pkg::*;

  // Shadow of the parser state and of the size limit register.
  phase_e      parse_phase;
  logic        cr_seen;
  logic [31:0] chunk_left;
  logic [31:0] decoded_count;
  logic [31:0] body_limit;

  // Output beats predicted but not yet seen, oldest first.
  result_t     expected_beats[$];
  int unsigned mismatches;

  // Advances the shadow parser by one raw byte and tells whether it yields a beat.
  task automatic decode_byte(input logic [7:0] c, input logic restart,
                             output bit produced, output result_t beat);
    logic [3:0] nib;
    logic       is_hex;
    produced = 1'b0;
    beat = '0;
    is_hex = 1'b1;
    nib = '0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 10);
    end else if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 10);
    end else begin
      is_hex = 1'b0;
    end
    if (restart) begin
      parse_phase = PH_DIGITS;
      cr_seen = 1'b0;
      chunk_left = '0;
      decoded_count = '0;
    end
    case (parse_phase)
      PH_DIGITS: begin
        if (is_hex) begin
          // A digit that would push the size past 32 bits ends the body.
          if (chunk_left[31:28] != 4'd0) begin
            parse_phase = PH_HALT;
            produced = 1'b1;
            beat.kind = KIND_FRAMING;
          end else begin
            chunk_left = {chunk_left[27:0], nib};
          end
        end else begin
          parse_phase = PH_EXT;
          cr_seen = (c == CH_CR);
        end
      end
      PH_EXT: begin
        if (cr_seen && c == CH_LF) begin
          cr_seen = 1'b0;
          if (chunk_left == '0) begin
            parse_phase = PH_TRAILER;
          end else begin
            parse_phase = PH_DATA;
          end
        end else begin
          cr_seen = (c == CH_CR);
        end
      end
      PH_DATA: begin
        if (decoded_count != '1) begin
          decoded_count = decoded_count + 1;
        end
        chunk_left = chunk_left - 1;
        if (chunk_left == '0) begin
          parse_phase = PH_DATA_CR;
        end
        produced = 1'b1;
        beat.kind = KIND_BYTE;
        beat.body_byte = c;
      end
      PH_DATA_CR: begin
        if (c != CH_CR) begin
          parse_phase = PH_HALT;
          produced = 1'b1;
          beat.kind = KIND_FRAMING;
        end else begin
          parse_phase = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (c != CH_LF) begin
          parse_phase = PH_HALT;
          produced = 1'b1;
          beat.kind = KIND_FRAMING;
        end else begin
          parse_phase = PH_DIGITS;
          chunk_left = '0;
          cr_seen = 1'b0;
        end
      end
      PH_TRAILER: begin
        // The first CR LF after the last chunk closes the body.
        if (cr_seen && c == CH_LF) begin
          cr_seen = 1'b0;
          parse_phase = PH_HALT;
          produced = 1'b1;
          if (body_limit != '0 && decoded_count > body_limit) begin
            beat.kind = KIND_TOO_LARGE;
          end else begin
            beat.kind = KIND_DONE;
          end
        end else begin
          cr_seen = (c == CH_CR);
        end
      end
      default: begin
      end
    endcase
    beat.total_length = decoded_count;
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit      produced;
    result_t beat;
    result_t want;
    if (!rst_ni) begin
      parse_phase = PH_DIGITS;
      cr_seen = 1'b0;
      chunk_left = '0;
      decoded_count = '0;
      body_limit = '0;
      expected_beats.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_beats_o <= 0;
    end else begin
      if (cfg_we_i) begin
        body_limit = cfg_wdata_i;
      end
      // Outgoing beat against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: result_kind %0d, body_byte %0h, total_length %0d",
                 result_kind_i, body_byte_i, total_length_i);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (result_kind_i !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, result_kind_i);
            mismatches++;
          end
          if (body_byte_i !== want.body_byte) begin
            $error("body_byte: expected %0h, actual %0h", want.body_byte, body_byte_i);
            mismatches++;
          end
          if (total_length_i !== want.total_length) begin
            $error("total_length: expected %0d, actual %0d", want.total_length,
                   total_length_i);
            mismatches++;
          end
        end
      end
      // Incoming beat through the shadow parser.
      if (in_valid_i && !in_stall_i) begin
        decode_byte(data_byte_i, start_req_i, produced, beat);
        if (produced) begin
          expected_beats.push_back(beat);
        end
      end
      mismatch_count_o <= mismatches;
      pending_beats_o <= expected_beats.size();
    end
  end

endmodule

// File: tb/http_chunked_body_decoder_top_test.sv
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_test;

  import hcbd_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned PHASE_BEATS  = 340;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        start_req;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  body_byte;
  logic [31:0] total_length;

  int unsigned mismatches;
  int unsigned pending_beats;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned beats_sent = 0;
  logic        fresh_body = 1'b0;

  always #2 clk = ~clk;

  http_chunked_body_decoder_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .start_req_i    (start_req),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .body_byte_o    (body_byte),
    .total_length_o (total_length)
  );

  hcbd_body_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .start_req_i      (start_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_i    (result_kind),
    .body_byte_i      (body_byte),
    .total_length_i   (total_length),
    .mismatch_count_o (mismatches),
    .pending_beats_o  (pending_beats)
  );

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) begin
      return 8'("0" + nib);
    end
    return upper ? 8'("A" + nib - 10) : 8'("a" + nib - 10);
  endfunction

  // Random byte for extensions and trailers: never LF, often a lone CR.
  function automatic logic [7:0] line_noise();
    logic [7:0] b;
    b = ($urandom_range(0, 3) == 0) ? CH_CR : 8'($urandom_range(0, 255));
    return (b == CH_LF) ? 8'("x") : b;
  endfunction

  // Sends one beat after an optional idle gap and waits until it is taken.
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_req <= fresh_body;
    fresh_body = 1'b0;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Holds the sender until every predicted beat has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Size line with random case, leading zeros and extension, then CR LF.
  task automatic send_size_line(input int unsigned len);
    int unsigned digits;
    int unsigned pad;
    logic        upper;
    upper = $urandom_range(0, 1);
    digits = 1;
    while (digits < 8 && (len >> (4 * digits)) != 0) begin
      digits++;
    end
    pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    // A last chunk sometimes comes with no digits at all.
    if (!(len == 0 && $urandom_range(0, 3) == 0)) begin
      repeat (pad) send_beat("0");
      for (int i = digits - 1; i >= 0; i--) begin
        send_beat(hex_char(4'(len >> (4 * i)), upper));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      send_beat(";");
      repeat ($urandom_range(0, 6)) send_beat(line_noise());
    end
    send_beat(CH_CR);
    send_beat(CH_LF);
  endtask

  // One body: mostly well formed, sometimes broken, cut short or pure noise.
  task automatic send_body();
    int unsigned flaw;
    int unsigned chunks;
    int unsigned len;
    logic [7:0]  b;
    logic        upper;
    flaw = $urandom_range(0, 19);
    upper = $urandom_range(0, 1);
    fresh_body = 1'b1;
    if (flaw == 19) begin
      // Noise with scattered start flags.
      repeat ($urandom_range(1, 6)) begin
        fresh_body = ($urandom_range(0, 3) == 0);
        send_beat(8'($urandom_range(0, 255)));
      end
      return;
    end
    if (flaw >= 17) begin
      // Eight digits with a nonzero top digit, then either a ninth digit
      // that overflows or a huge chunk abandoned after a few bytes.
      send_beat(hex_char(4'($urandom_range(1, 15)), upper));
      repeat (7) send_beat(hex_char(4'($urandom_range(0, 15)), upper));
      if (flaw == 17) begin
        send_beat(hex_char(4'($urandom_range(0, 15)), upper));
        repeat ($urandom_range(0, 2)) send_beat(8'($urandom_range(0, 255)));
      end else begin
        send_beat(CH_CR);
        send_beat(CH_LF);
        repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)));
      end
      return;
    end
    chunks = $urandom_range(0, 3);
    for (int c = 0; c < chunks; c++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      send_size_line(len);
      repeat (len) send_beat(8'($urandom_range(0, 255)));
      if (flaw == 16 && c == chunks - 1) begin
        // Break the chunk end, either at its CR or at its LF.
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
          send_beat((b == CH_CR) ? CH_LF : b);
        end else begin
          send_beat(CH_CR);
          send_beat((b == CH_LF) ? CH_CR : b);
        end
        return;
      end
      send_beat(CH_CR);
      send_beat(CH_LF);
    end
    if (flaw == 15) begin
      return;
    end
    send_size_line(0);
    repeat ($urandom_range(0, 5)) send_beat(line_noise());
    send_beat(CH_CR);
    send_beat(CH_LF);
    // Bytes after the end are dropped by the block.
    if (flaw < 4) begin
      repeat ($urandom_range(1, 2)) send_beat(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [31:0] limits [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    start_req = 1'b0;
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'd1;
    limits[2] = $urandom_range(2, 40);
    limits[3] = 32'd0;
    limits[4] = $urandom;
    limits[5] = $urandom_range(1, 24);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 25;
    sink_idle_pct = 69;

    // Empty size line taken as the last chunk, then a byte after the end.
    fresh_body = 1'b1;
    send_beat(CH_CR);
    send_beat(CH_LF);
    send_beat(CH_CR);
    send_beat(CH_LF);
    send_beat("x");
    // Lone CR in an extension, extreme data bytes, missing CR at chunk end.
    fresh_body = 1'b1;
    send_beat("2");
    send_beat(";");
    send_beat(CH_CR);
    send_beat(CH_CR);
    send_beat(CH_LF);
    send_beat(8'hFF);
    send_beat(8'h00);
    send_beat("Z");
    // Ninth digit overflows the size.
    fresh_body = 1'b1;
    send_beat("F");
    repeat (8) send_beat("0");
    // CR at chunk end followed by something other than LF.
    fresh_body = 1'b1;
    send_beat("1");
    send_beat(CH_CR);
    send_beat(CH_LF);
    send_beat(8'h80);
    send_beat(CH_CR);
    send_beat("Q");

    // Random bodies under several size limits and idle patterns.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(limits[p]);
      src_idle_pct = (p < 2) ? 25 : (p < 4) ? 69 : 0;
      sink_idle_pct = (p < 2) ? 69 : (p < 4) ? 25 : 0;
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) begin
        send_body();
        if ($urandom_range(0, 15) == 0) begin
          settle();
        end
      end
    end

    settle();
    if (mismatches == 0 && pending_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
